// ===== rtl/core/oale_pkg.sv =====
package oale_pkg;

  // Field widths fixed by the request and result formats
  localparam int REQ_W    = 2;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_e_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_CLEAR  = 3'd1,
    CELL_SEARCH = 3'd2,
    CELL_INSERT = 3'd3,
    CELL_REMOVE = 3'd4
  } cell_op_e_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_INSERT = 3'd1,
    S_SEARCH = 3'd2,
    S_FINISH = 3'd3,
    S_RESP   = 3'd4
  } state_e_t;

endpackage

// ===== rtl/core/ordered_array_list_engine.sv =====
// Ordered list of CAPACITY words held in a chain of cells, one word per cell.
// Input channel (in_valid/in_ready): in_req_type selects insert at
// in_position, append, remove first match or membership lookup of in_value.
// Result channel (out_valid/out_ready): one transaction per request with
// out_status (ok/found, full, bad position, not found) and out_item_count.
// Remove and lookup wait for the match flag to ripple one cell per cycle
// from slot 0 to the top slot. Insert, and remove once that search is done,
// move every affected cell in a single parallel shift.
// One request is in flight at a time: in_ready is high only while idle, and
// the next request is taken the cycle after the result transaction.
// A stalled receiver holds the result and the block in place.
// Reset (rst_n low, synchronous) empties the list; stored words are not
// cleared and are never read before being written.
module ordered_array_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [oale_pkg::REQ_W-1:0]     in_req_type,
  input  logic [oale_pkg::POS_W-1:0]     in_position,
  input  logic [oale_pkg::VAL_W-1:0]     in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [oale_pkg::STATUS_W-1:0]  out_status,
  output logic [oale_pkg::COUNT_W-1:0]   out_item_count
);
  import oale_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_op_e_t            cell_op;
  logic [DATA_WIDTH-1:0] key;
  logic [CNT_W-1:0]      pos;
  logic [CNT_W-1:0]      count;
  logic [DATA_WIDTH-1:0] data_w [CAPACITY];
  logic                  hit_w  [CAPACITY];

  oale_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_item_count (out_item_count),
    .cell_op        (cell_op),
    .key            (key),
    .pos            (pos),
    .count          (count),
    .found          (hit_w[CAPACITY-1])
  );

  // Cell chain: slot 0 at the bottom, neighbors wired both ways
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_data;
    logic [DATA_WIDTH-1:0] upper_data;
    logic                  lower_hit;

    if (i == 0) begin : g_bottom
      assign lower_data = key;
      assign lower_hit  = 1'b0;
    end else begin : g_lower
      assign lower_data = data_w[i-1];
      assign lower_hit  = hit_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign upper_data = key;
    end else begin : g_upper
      assign upper_data = data_w[i+1];
    end

    oale_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_op    (cell_op),
      .key        (key),
      .pos        (pos),
      .count      (count),
      .lower_data (lower_data),
      .upper_data (upper_data),
      .lower_hit  (lower_hit),
      .data       (data_w[i]),
      .hit        (hit_w[i])
    );
  end

endmodule

// ===== rtl/core/oale_cell.sv =====
// One slot of the list: holds a word and a running "match at or below" flag.
module oale_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  oale_pkg::cell_op_e_t   cell_op,
  input  logic [DATA_WIDTH-1:0]  key,
  input  logic [CNT_W-1:0]       pos,
  input  logic [CNT_W-1:0]       count,
  input  logic [DATA_WIDTH-1:0]  lower_data,
  input  logic [DATA_WIDTH-1:0]  upper_data,
  input  logic                   lower_hit,
  output logic [DATA_WIDTH-1:0]  data,
  output logic                   hit
);
  import oale_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  hit_r;
  logic                  hit_nxt;
  logic                  occupied;

  assign occupied = IDX_C < count;

  // Slot update: insert shifts up from below, remove pulls down from above
  always_comb begin
    data_nxt = data_r;
    hit_nxt  = hit_r;
    case (cell_op)
      CELL_CLEAR: begin
        hit_nxt = 1'b0;
      end
      CELL_SEARCH: begin
        hit_nxt = lower_hit | (occupied && (data_r == key));
      end
      CELL_INSERT: begin
        if (IDX_C == pos) begin
          data_nxt = key;
        end else if (IDX_C > pos) begin
          data_nxt = lower_data;
        end
      end
      CELL_REMOVE: begin
        if (hit_r) begin
          data_nxt = upper_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

// ===== rtl/core/oale_ctrl.sv =====
// Request sequencer: checks, drives the cell chain, keeps the count and result.
module oale_ctrl #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [oale_pkg::REQ_W-1:0]     in_req_type,
  input  logic [oale_pkg::POS_W-1:0]     in_position,
  input  logic [oale_pkg::VAL_W-1:0]     in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [oale_pkg::STATUS_W-1:0]  out_status,
  output logic [oale_pkg::COUNT_W-1:0]   out_item_count,
  output oale_pkg::cell_op_e_t           cell_op,
  output logic [DATA_WIDTH-1:0]          key,
  output logic [CNT_W-1:0]               pos,
  output logic [CNT_W-1:0]               count,
  input  logic                           found
);
  import oale_pkg::*;

  localparam int TICK_W = $clog2(CAPACITY);
  localparam int PW     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int KW     = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int OW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(CAPACITY);
  localparam logic [TICK_W-1:0] LAST_T = TICK_W'(CAPACITY - 1);

  state_e_t              state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic                  rem_r, rem_nxt;
  status_e_t             status_r, status_nxt;

  logic                  accept;
  req_e_t                req;
  logic                  full;
  logic                  bad_pos;
  logic [PW-1:0]         pos_ext;
  logic [KW-1:0]         val_ext;
  logic [OW-1:0]         cnt_ext;

  assign accept  = in_valid && in_ready;
  assign req     = req_e_t'(in_req_type);
  assign full    = cnt_r == CAP_C;
  assign pos_ext = PW'(in_position);
  assign bad_pos = pos_ext > PW'(cnt_r);
  assign val_ext = KW'(in_value);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (req == REQ_REMOVE || req == REQ_LOOKUP) begin
            state_nxt = S_SEARCH;
          end else if (full || (req == REQ_INSERT && bad_pos)) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_INSERT;
          end
        end
      end
      S_INSERT: state_nxt = S_RESP;
      S_SEARCH: begin
        if (tick_r == LAST_T) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: state_nxt = S_RESP;
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cell_op   = CELL_HOLD;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cell_op = CELL_CLEAR;
        end
      end
      S_INSERT: cell_op = CELL_INSERT;
      S_SEARCH: cell_op = CELL_SEARCH;
      S_FINISH: begin
        if (rem_r && found) begin
          cell_op = CELL_REMOVE;
        end
      end
      S_RESP:  out_valid = 1'b1;
      default: cell_op = CELL_HOLD;
    endcase
  end

  // Request registers, count and result status
  always_comb begin
    cnt_nxt    = cnt_r;
    tick_nxt   = tick_r;
    key_nxt    = key_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    status_nxt = status_r;
    if (accept) begin
      key_nxt  = val_ext[DATA_WIDTH-1:0];
      rem_nxt  = req == REQ_REMOVE;
      tick_nxt = '0;
      pos_nxt  = (req == REQ_INSERT) ? pos_ext[CNT_W-1:0] : cnt_r;
      if (req == REQ_REMOVE || req == REQ_LOOKUP) begin
        status_nxt = ST_OK;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else if (req == REQ_INSERT && bad_pos) begin
        status_nxt = ST_BAD_POS;
      end else begin
        status_nxt = ST_OK;
      end
    end
    if (state_r == S_INSERT) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (state_r == S_SEARCH) begin
      tick_nxt = tick_r + 1'b1;
    end
    if (state_r == S_FINISH) begin
      status_nxt = found ? ST_OK : ST_NOT_FOUND;
      if (rem_r && found) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_r   <= tick_nxt;
    key_r    <= key_nxt;
    pos_r    <= pos_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
  end

  assign cnt_ext        = OW'(cnt_r);
  assign out_status     = status_r;
  assign out_item_count = cnt_ext[COUNT_W-1:0];
  assign key            = key_r;
  assign pos            = pos_r;
  assign count          = cnt_r;

endmodule

// ===== rtl/core/oale_chk.sv =====
// Port-level checks for the list engine.
module oale_chk #(
  parameter int CAPACITY = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [oale_pkg::STATUS_W-1:0]  out_status,
  input logic [oale_pkg::COUNT_W-1:0]   out_item_count
);
  import oale_pkg::*;

  // Count reported never exceeds capacity (when it fits the field)
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 31 || 32'(out_item_count) <= 32'(CAPACITY)))
    else $error("item count above capacity");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_item_count))
    else $error("stalled result changed");

  // No new request while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready with result pending");

  // An accepted request keeps the input closed in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

endmodule

bind ordered_array_list_engine oale_chk #(.CAPACITY(CAPACITY)) u_oale_chk (.*);
